// File: design/u8d_pkg.sv
package u8d_pkg;

    localparam int MaxResults = 3;
    localparam int PendDepth = 3;

    localparam logic [20:0] ReplacementCp = 21'h00FFFD;

    // sequence length codes from a lead byte
    localparam logic [2:0] LenInvalid = 3'd0;
    localparam logic [2:0] LenOne = 3'd1;
    localparam logic [2:0] LenTwo = 3'd2;
    localparam logic [2:0] LenThree = 3'd3;
    localparam logic [2:0] LenFour = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [20:0] code_point;
        logic        run_end;
        logic        string_end;
    } out_item_t;

    // one group of results produced by one input byte
    typedef struct packed {
        out_item_t [MaxResults-1:0] items;
        logic [1:0]                 count;
    } result_grp_t;

    // pending state update from the decoder
    typedef struct packed {
        logic       hold;
        logic [1:0] slot;
        logic [1:0] count_next;
    } pend_ctl_t;

    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        begin
            if (b[7] == 1'b0)
                len = LenOne;
            else if ((b & 8'hE0) == 8'hC0)
                len = LenTwo;
            else if ((b & 8'hF0) == 8'hE0)
                len = LenThree;
            else if ((b & 8'hF8) == 8'hF0)
                len = LenFour;
            else
                len = LenInvalid;
            return len;
        end
    endfunction

    function automatic logic [20:0] assemble(
        input logic [7:0] b0,
        input logic [7:0] b1,
        input logic [7:0] b2,
        input logic [7:0] b3,
        input logic [2:0] len
    );
        logic [20:0] cp;
        begin
            case (len)
                LenOne:   cp = {13'd0, b0};
                LenTwo:   cp = {10'd0, b0[4:0], b1[5:0]};
                LenThree: cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
                default:  cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            endcase
            return cp;
        end
    endfunction

    // a lone byte decoded as a fresh lead with nothing after it
    function automatic logic [20:0] single_cp(input logic [7:0] b);
        logic [20:0] cp;
        begin
            if (b[7] == 1'b0)
                cp = {13'd0, b};
            else
                cp = ReplacementCp;
            return cp;
        end
    endfunction

endpackage

// File: design/u8d_decode.sv
module u8d_decode (
    input  logic [7:0]        pend0,
    input  logic [7:0]        pend1,
    input  logic [7:0]        pend2,
    input  logic [1:0]        pend_cnt,
    input  u8d_pkg::in_item_t item,
    output u8d_pkg::result_grp_t grp,
    output u8d_pkg::pend_ctl_t   ctl
);

    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [7:0] b3;
    logic [2:0] n;
    logic [2:0] need;
    logic [2:0] tail_len;

    // held bytes first, then the new byte
    assign b0 = (pend_cnt > 2'd0) ? pend0 : item.data_byte;
    assign b1 = (pend_cnt > 2'd1) ? pend1 : item.data_byte;
    assign b2 = (pend_cnt > 2'd2) ? pend2 : item.data_byte;
    assign b3 = item.data_byte;
    assign n = {1'b0, pend_cnt} + 3'd1;
    assign need = u8d_pkg::lead_length(b0);
    assign tail_len = u8d_pkg::lead_length(b1);

    always_comb
    begin
        grp = '0;
        ctl.hold = 1'b0;
        ctl.slot = pend_cnt;
        ctl.count_next = 2'd0;
        if (!item.final_byte)
        begin
            grp.items[0].run_end = 1'b1;
            if (need == u8d_pkg::LenInvalid)
            begin
                grp.items[0].code_point = u8d_pkg::ReplacementCp;
                grp.count = 2'd1;
            end
            else if (n >= need)
            begin
                grp.items[0].code_point = u8d_pkg::assemble(b0, b1, b2, b3, need);
                grp.count = 2'd1;
            end
            else
            begin
                ctl.hold = 1'b1;
                ctl.count_next = n[1:0];
            end
        end
        else if (need != u8d_pkg::LenInvalid && n >= need)
        begin
            grp.items[0] = '{u8d_pkg::assemble(b0, b1, b2, b3, need), 1'b1, 1'b1};
            grp.count = 2'd1;
        end
        else if (n == 3'd1)
        begin
            grp.items[0] = '{u8d_pkg::ReplacementCp, 1'b1, 1'b1};
            grp.count = 2'd1;
        end
        else
        begin
            // truncated lead, rest decoded again as fresh leads
            grp.items[0] = '{u8d_pkg::ReplacementCp, 1'b0, 1'b0};
            if (n == 3'd2)
            begin
                grp.items[1] = '{u8d_pkg::single_cp(b1), 1'b1, 1'b1};
                grp.count = 2'd2;
            end
            else if (tail_len == u8d_pkg::LenTwo)
            begin
                grp.items[1] = '{u8d_pkg::assemble(b1, b2, b3, b3, u8d_pkg::LenTwo),
                                 1'b1, 1'b1};
                grp.count = 2'd2;
            end
            else
            begin
                grp.items[1] = '{u8d_pkg::single_cp(b1), 1'b0, 1'b0};
                grp.items[2] = '{u8d_pkg::single_cp(b2), 1'b1, 1'b1};
                grp.count = 2'd3;
            end
        end
    end

endmodule

// File: design/u8d_result_queue.sv
module u8d_result_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  u8d_pkg::result_grp_t  grp,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output u8d_pkg::out_item_t    out_item
);

    u8d_pkg::out_item_t [u8d_pkg::MaxResults-1:0] items_reg;
    logic [1:0] rem_reg;
    logic [1:0] rem_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       pop;

    assign out_valid = (rem_reg != 2'd0);
    assign pop = out_valid && out_ready;
    // last waiting result leaves this cycle, so a new group fits
    assign can_load = (rem_reg == 2'd0) || (rem_reg == 2'd1 && out_ready);
    assign out_item = items_reg[idx_reg];

    always_comb
    begin
        rem_next = rem_reg;
        idx_next = idx_reg;
        if (load)
        begin
            rem_next = grp.count;
            idx_next = 2'd0;
        end
        else if (pop)
        begin
            rem_next = rem_reg - 2'd1;
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else
        begin
            rem_reg <= rem_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            items_reg <= grp.items;
    end

endmodule

// File: design/utf8_byte_stream_decoder.sv
// utf8 byte stream decoder
// in channel: one string byte per transfer (in_valid/in_ready, in_data), with
// final_byte set on the last byte of a string
// out channel: decoded code points (out_valid/out_ready, out_data); 0xFFFD marks
// a bad lead byte or a lead cut off by the end of the string
// run_end marks the last code point caused by one input byte, string_end the
// last code point of the whole string
// a byte that completes a sequence shows its code point in the cycle after
// its transfer; bytes inside a sequence give nothing and are held here
// throughput: one byte per cycle while out_ready stays high; a final byte that flushes a truncated
// sequence gives up to three code points, and input waits while the extra
// ones drain from the result register, one per cycle
// the result register takes a new group in the same cycle its last code point
// leaves, so input and output run back to back
// when the receiver stalls, results stay in the result register and in_ready
// drops once a group is waiting that cannot leave this cycle
// reset clears the held byte count and empties the result register; a new string
// starts on the first byte after reset
module utf8_byte_stream_decoder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  u8d_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output u8d_pkg::out_item_t  out_data
);

    // bytes of an unfinished sequence, lead first
    logic [7:0] pend_reg [u8d_pkg::PendDepth];
    logic [1:0] pend_cnt_reg;
    logic [1:0] pend_cnt_next;

    u8d_pkg::result_grp_t grp;
    u8d_pkg::pend_ctl_t   ctl;
    logic                 in_xfer;

    assign in_xfer = in_valid && in_ready;

    // combinational decode of held bytes plus the incoming byte
    u8d_decode u_decode (
        .pend0    (pend_reg[0]),
        .pend1    (pend_reg[1]),
        .pend2    (pend_reg[2]),
        .pend_cnt (pend_cnt_reg),
        .item     (in_data),
        .grp      (grp),
        .ctl      (ctl)
    );

    // result register, emits a group one code point per cycle while out_ready is high
    u8d_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_xfer),
        .grp       (grp),
        .can_load  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_data)
    );

    // held count clears whenever a byte produces results
    assign pend_cnt_next = in_xfer ? ctl.count_next : pend_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_cnt_reg <= 2'd0;
        else
            pend_cnt_reg <= pend_cnt_next;
    end

    // held bytes need no reset, only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (in_xfer && ctl.hold)
            pend_reg[ctl.slot] <= in_data.data_byte;
    end

    // end of string always leaves nothing held
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_data.final_byte |=> pend_cnt_reg == 2'd0)
        else $error("held bytes left after final byte");

    // a stalled result blocks new input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while result is stalled");

    // a byte inside a sequence gives no result
    a_hold_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && ctl.hold |=> !out_valid)
        else $error("result shown for a held byte");

    // string end only on the last result of a byte
    a_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.string_end |-> out_data.run_end)
        else $error("string_end without run_end");

endmodule

// File: sim/utf8_byte_stream_decoder_test.sv
module utf8_byte_stream_decoder_test;

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #4 clk = ~clk;

    // block ports, all driven to known values from time zero
    logic               in_valid = 1'b0;
    logic               in_ready;
    u8d_pkg::in_item_t  in_data = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    u8d_pkg::out_item_t out_data;

    utf8_byte_stream_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // string bytes waiting to be offered, and code points still owed by the block
    u8d_pkg::in_item_t  byte_backlog [$];
    u8d_pkg::out_item_t expected_cps [$];

    // own copy of the bytes of an unfinished sequence
    logic [7:0] held_bytes [3] = '{8'h00, 8'h00, 8'h00};
    logic [1:0] held_cnt = 2'd0;

    // idle rates in percent, changed per phase
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // long receiver hold-off, requested once from the stimulus
    logic hold_armed = 1'b0;
    logic hold_used = 1'b0;
    int   hold_left = 0;

    int   bytes_queued = 0;
    int   bytes_taken = 0;
    int   mismatch_cnt = 0;
    logic in_fired = 1'b0;
    u8d_pkg::out_item_t want;

    // sequence length picked by a lead byte
    function automatic logic [2:0] seq_len(input logic [7:0] b);
        logic [2:0] len;
        begin
            casez (b)
                8'b0???????: len = u8d_pkg::LenOne;
                8'b110?????: len = u8d_pkg::LenTwo;
                8'b1110????: len = u8d_pkg::LenThree;
                8'b11110???: len = u8d_pkg::LenFour;
                default:     len = u8d_pkg::LenInvalid;
            endcase
            return len;
        end
    endfunction

    // join len bytes starting at position at: lead payload, then six bits per
    // continuation byte, continuation marks not checked
    function automatic logic [20:0] decode_at(input logic [3:0][7:0] w, input int at,
                                              input int len);
        logic [20:0] cp;
        begin
            case (len)
                1:       cp = 21'(w[at]);
                2:       cp = 21'(w[at] & 8'h1F);
                3:       cp = 21'(w[at] & 8'h0F);
                default: cp = 21'(w[at] & 8'h07);
            endcase
            for (int i = 1; i < len; i++)
                cp = (cp << 6) | 21'(w[at + i] & 8'h3F);
            return cp;
        end
    endfunction

    // predict the code points caused by one accepted byte
    task automatic decode_byte(input u8d_pkg::in_item_t it);
        logic [3:0][7:0]    window;
        logic [20:0]        cps [3];
        int                 n;
        int                 pos;
        int                 k;
        int                 len;
        u8d_pkg::out_item_t r;
        begin
            window = '0;
            for (int i = 0; i < int'(held_cnt); i++)
                window[i] = held_bytes[i];
            n = int'(held_cnt);
            window[n] = it.data_byte;
            n++;
            len = int'(seq_len(window[0]));
            if (!it.final_byte) begin
                r.run_end = 1'b1;
                r.string_end = 1'b0;
                if (len == u8d_pkg::LenInvalid) begin
                    held_cnt = 2'd0;
                    r.code_point = u8d_pkg::ReplacementCp;
                    expected_cps = {expected_cps, r};
                end else if (n >= len) begin
                    held_cnt = 2'd0;
                    r.code_point = decode_at(window, 0, len);
                    expected_cps = {expected_cps, r};
                end else begin
                    // sequence still open: hold its bytes
                    for (int i = 0; i < n; i++)
                        held_bytes[i] = window[i];
                    held_cnt = 2'(n);
                end
            end else begin
                // end of string: flush, a cut lead gives the replacement and the
                // bytes after it start over as leads
                pos = 0;
                k = 0;
                while (pos < n && k < 3) begin
                    len = int'(seq_len(window[pos]));
                    if (len != u8d_pkg::LenInvalid && pos + len <= n) begin
                        cps[k] = decode_at(window, pos, len);
                        pos += len;
                    end else begin
                        cps[k] = u8d_pkg::ReplacementCp;
                        pos++;
                    end
                    k++;
                end
                held_cnt = 2'd0;
                for (int i = 0; i < k; i++) begin
                    r.code_point = cps[i];
                    r.run_end = (i == k - 1);
                    r.string_end = (i == k - 1);
                    expected_cps = {expected_cps, r};
                end
            end
        end
    endtask

    // sender: new byte at the falling edge once the last one was taken
    always @(negedge clk) begin
        if (rst_n) begin
            if (!in_valid || in_fired) begin
                if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_data <= byte_backlog.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: random stalls, plus one long hold-off so the block backs up
    always @(negedge clk) begin
        if (hold_left != 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_armed && !hold_used) begin
            out_ready <= 1'b0;
            hold_left <= 80;
            hold_used <= 1'b1;
        end else if (rst_n) begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // monitor: predict on each input transfer, check each output transfer
    always @(posedge clk) begin
        in_fired <= rst_n && in_valid && in_ready;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                decode_byte(in_data);
                bytes_taken++;
            end
            if (out_valid && out_ready) begin
                if (expected_cps.size() == 0) begin
                    $error("code_point: expected none, actual %h", out_data.code_point);
                    mismatch_cnt++;
                end else begin
                    want = expected_cps.pop_front();
                    if (out_data.code_point !== want.code_point) begin
                        $error("code_point: expected %h, actual %h",
                               want.code_point, out_data.code_point);
                        mismatch_cnt++;
                    end
                    if (out_data.run_end !== want.run_end) begin
                        $error("run_end: expected %b, actual %b",
                               want.run_end, out_data.run_end);
                        mismatch_cnt++;
                    end
                    if (out_data.string_end !== want.string_end) begin
                        $error("string_end: expected %b, actual %b",
                               want.string_end, out_data.string_end);
                        mismatch_cnt++;
                    end
                end
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b, input logic fin);
        u8d_pkg::in_item_t it;
        begin
            it.data_byte = b;
            it.final_byte = fin;
            byte_backlog = {byte_backlog, it};
            bytes_queued++;
        end
    endtask

    // mostly a proper continuation byte, now and then any byte at all
    function automatic logic [7:0] cont_byte();
        logic [7:0] b;
        begin
            if ($urandom_range(0, 15) == 0)
                b = 8'($urandom_range(0, 255));
            else
                b = 8'h80 | 8'($urandom_range(0, 63));
            return b;
        end
    endfunction

    // one string of random characters, sometimes with up to three bytes cut from its end
    task automatic queue_random_string();
        logic [7:0] chars [$];
        int         nchars;
        int         kind;
        int         cut;
        begin
            nchars = $urandom_range(1, 6);
            for (int c = 0; c < nchars; c++) begin
                kind = $urandom_range(0, 99);
                if (kind < 30) begin
                    chars = {chars, 8'($urandom_range(0, 127))};
                end else if (kind < 50) begin
                    chars = {chars, 8'hC0 | 8'($urandom_range(0, 31))};
                    chars = {chars, cont_byte()};
                end else if (kind < 72) begin
                    chars = {chars, 8'hE0 | 8'($urandom_range(0, 15))};
                    chars = {chars, cont_byte()};
                    chars = {chars, cont_byte()};
                end else if (kind < 90) begin
                    chars = {chars, 8'hF0 | 8'($urandom_range(0, 7))};
                    chars = {chars, cont_byte()};
                    chars = {chars, cont_byte()};
                    chars = {chars, cont_byte()};
                end else begin
                    // noise, covers stray continuations and bad leads
                    chars = {chars, 8'($urandom_range(0, 255))};
                end
            end
            if ($urandom_range(0, 3) == 0 && chars.size() > 1) begin
                cut = $urandom_range(1, (chars.size() > 3) ? 3 : chars.size() - 1);
                repeat (cut) void'(chars.pop_back());
            end
            foreach (chars[i])
                queue_byte(chars[i], i == chars.size() - 1);
        end
    endtask

    // wait until every queued byte has gone in
    task automatic wait_all_taken();
        begin
            do
                @(negedge clk);
            while (bytes_taken != bytes_queued);
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // phase one: sender idles a little, receiver a lot
        @(posedge clk);
        send_idle_pct = 35;
        recv_idle_pct = 86;

        // directed: ascii extremes and every sequence length
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'hC2, 1'b0);
        queue_byte(8'hA9, 1'b0);
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b0);
        queue_byte(8'hAC, 1'b0);
        queue_byte(8'hF7, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        queue_byte(8'hBF, 1'b0);
        // bad leads with nothing held
        queue_byte(8'h80, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // four byte lead cut at end of string: replacement then two ascii
        queue_byte(8'hF0, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(8'h42, 1'b1);
        // three byte lead cut: replacement, then a stray continuation
        queue_byte(8'hE2, 1'b0);
        queue_byte(8'h82, 1'b1);
        // sequence completed by the final byte
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'hA9, 1'b1);
        // one byte strings, good and bad
        queue_byte(8'h41, 1'b1);
        queue_byte(8'hF8, 1'b1);

        while (bytes_queued < 150)
            queue_random_string();
        wait_all_taken();

        // phase two: the other way round
        @(posedge clk);
        send_idle_pct = 86;
        recv_idle_pct = 35;
        while (bytes_queued < 280)
            queue_random_string();
        wait_all_taken();

        // phase three: no idling, with a long receiver hold-off at its start
        @(posedge clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_armed = 1'b1;
        while (bytes_queued < 410)
            queue_random_string();
        wait_all_taken();

        // drain, then keep watching for any extra output before the verdict
        while (expected_cps.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// File: utf8_byte_stream_decoder.f
design/u8d_pkg.sv
design/u8d_decode.sv
design/u8d_result_queue.sv
design/utf8_byte_stream_decoder.sv
sim/utf8_byte_stream_decoder_test.sv
